// File: rtl/cbd_pkg.sv
// Shared types, character codes and helpers for the chunked body decoder.
// No dependencies; every other file refers to it by scoped names.
package cbd_pkg;

  localparam int COUNT_WIDTH = 32;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_X_LO  = 8'h78;
  localparam logic [7:0] CHAR_X_UP  = 8'h58;

  typedef enum logic [1:0] {
    STATUS_BUSY = 2'd0,
    STATUS_OK   = 2'd1,
    STATUS_BAD  = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    MODE_LINE_START = 5'b00001,
    MODE_LINE       = 5'b00010,
    MODE_DATA       = 5'b00100,
    MODE_OPT_CR     = 5'b01000,
    MODE_OPT_LF     = 5'b10000
  } mode_e;

  typedef enum logic [3:0] {
    PHASE_BLANK  = 4'b0001,
    PHASE_ZERO   = 4'b0010,
    PHASE_DIGITS = 4'b0100,
    PHASE_SKIP   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    status_e    decode_status;
  } result_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

// File: rtl/cbd_in_reg.sv
// Input register stage of the chunked body decoder.
// Uses cbd_pkg::item_t.
module cbd_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cbd_pkg::item_t item_i,
  input  logic           adv_i,
  output logic           valid_o,
  output cbd_pkg::item_t item_o
);

  logic           valid_q;
  cbd_pkg::item_t item_q;

  // Hold the word while it waits for the parser.
  assign in_stall_o = valid_q && !adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/cbd_parser.sv
// Chunk framing state and its one-byte-per-cycle update while step_i is high.
// Uses cbd_pkg types, character codes and hex_decode.
module cbd_parser #(
  parameter int CountWidth = cbd_pkg::COUNT_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  cbd_pkg::item_t   item_i,
  output cbd_pkg::result_t res_o
);

  cbd_pkg::mode_e          mode_q, mode_d;
  cbd_pkg::phase_e         phase_q, phase_d;
  logic [CountWidth-1:0]   left_q, left_d;
  logic                    term_q, term_d;

  logic [7:0]              b;
  logic [4:0]              hex;
  logic                    line_en;
  logic [CountWidth-1:0]   digit_left;

  assign b   = item_i.data_byte;
  assign hex = cbd_pkg::hex_decode(b);

  // Saturate once any of the top four bits would shift out.
  assign digit_left = (|left_q[CountWidth-1 -: 4]) ? {CountWidth{1'b1}}
                    : {left_q[CountWidth-5:0], hex[3:0]};

  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    left_d  = left_q;
    term_d  = term_q;
    line_en = 1'b0;
    res_o   = '{payload_byte: 8'd0, payload_valid: 1'b0,
                decode_status: cbd_pkg::STATUS_BUSY};

    if (!term_q) begin
      case (mode_q)
        cbd_pkg::MODE_DATA: begin
          res_o.payload_byte  = b;
          res_o.payload_valid = 1'b1;
          left_d = left_q - CountWidth'(1);
          if (left_q == CountWidth'(1)) begin
            mode_d = cbd_pkg::MODE_OPT_CR;
          end
        end
        cbd_pkg::MODE_OPT_CR: begin
          if (b == cbd_pkg::CHAR_CR) begin
            mode_d = cbd_pkg::MODE_OPT_LF;
          end else if (b == cbd_pkg::CHAR_LF) begin
            mode_d = cbd_pkg::MODE_LINE_START;
          end else begin
            line_en = 1'b1;
          end
        end
        cbd_pkg::MODE_OPT_LF: begin
          if (b == cbd_pkg::CHAR_LF) begin
            mode_d = cbd_pkg::MODE_LINE_START;
          end else begin
            line_en = 1'b1;
          end
        end
        default: begin
          line_en = 1'b1;
        end
      endcase
    end

    if (line_en) begin
      if (b == cbd_pkg::CHAR_LF) begin
        if (left_q == '0) begin
          term_d = 1'b1;
        end else begin
          mode_d = cbd_pkg::MODE_DATA;
        end
        phase_d = cbd_pkg::PHASE_BLANK;
      end else begin
        mode_d = cbd_pkg::MODE_LINE;
        case (phase_q)
          cbd_pkg::PHASE_BLANK: begin
            if (b == cbd_pkg::CHAR_SPACE || b == cbd_pkg::CHAR_TAB) begin
              phase_d = cbd_pkg::PHASE_BLANK;
            end else if (b == cbd_pkg::CHAR_ZERO) begin
              phase_d = cbd_pkg::PHASE_ZERO;
            end else if (hex[4]) begin
              left_d  = digit_left;
              phase_d = cbd_pkg::PHASE_DIGITS;
            end else begin
              phase_d = cbd_pkg::PHASE_SKIP;
            end
          end
          cbd_pkg::PHASE_ZERO: begin
            if (b == cbd_pkg::CHAR_X_LO || b == cbd_pkg::CHAR_X_UP) begin
              phase_d = cbd_pkg::PHASE_DIGITS;
            end else if (hex[4]) begin
              left_d  = digit_left;
              phase_d = cbd_pkg::PHASE_DIGITS;
            end else begin
              phase_d = cbd_pkg::PHASE_SKIP;
            end
          end
          cbd_pkg::PHASE_DIGITS: begin
            if (hex[4]) begin
              left_d = digit_left;
            end else begin
              phase_d = cbd_pkg::PHASE_SKIP;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end

    // Report on the final word, then start a fresh body.
    if (item_i.last_byte) begin
      if (term_d) begin
        res_o.decode_status = cbd_pkg::STATUS_OK;
      end else if (mode_d == cbd_pkg::MODE_LINE || mode_d == cbd_pkg::MODE_DATA) begin
        res_o.decode_status = cbd_pkg::STATUS_BAD;
      end else begin
        res_o.decode_status = cbd_pkg::STATUS_OK;
      end
      mode_d  = cbd_pkg::MODE_LINE_START;
      phase_d = cbd_pkg::PHASE_BLANK;
      left_d  = '0;
      term_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= cbd_pkg::MODE_LINE_START;
      phase_q <= cbd_pkg::PHASE_BLANK;
      left_q  <= '0;
      term_q  <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      left_q  <= left_d;
      term_q  <= term_d;
    end
  end

endmodule

// File: rtl/cbd_out_reg.sv
// Result register of the chunked body decoder.
// Uses cbd_pkg::result_t.
module cbd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  cbd_pkg::result_t res_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cbd_pkg::result_t res_o
);

  logic             valid_q;
  cbd_pkg::result_t res_q;

  // Load when empty or when the held word leaves this cycle.
  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// File: rtl/chunked_body_decoder.sv
// Top level of the chunked body decoder.
// Instantiates cbd_in_reg, cbd_parser and cbd_out_reg; uses cbd_pkg.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o with data_byte_i and last_byte_i,
//   one raw body byte per word; last_byte_i marks the final byte of a body.
//   Output channel: out_valid_o / out_stall_i with payload_byte_o,
//   payload_valid_o and decode_status_o, exactly one word per input word.
//   decode_status_o is nonzero only on the word for the final byte
//   (1 ok, 2 malformed); after it the decoder starts a new body.
//   Path: a byte accepted into the input register passes the parser and is
//   captured in the result register, from which the receiver takes it.
//   Throughput: one byte per cycle while out_stall_i does not hold a result;
//   the framing state updates as each byte moves into the result register.
//   Stall: while out_stall_i holds a result, in_stall_o is high once the
//   input register is full; an empty one still takes one more word.
//   Reset: both registers empty, framing state at line start, count zero.
module chunked_body_decoder #(
  parameter int CountWidth = cbd_pkg::COUNT_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic       payload_valid_o,
  output logic [1:0] decode_status_o
);

  cbd_pkg::item_t   in_item;
  cbd_pkg::item_t   item_q;
  logic             item_valid;
  logic             out_ready;
  cbd_pkg::result_t res;
  cbd_pkg::result_t res_q;

  assign in_item = '{data_byte: data_byte_i, last_byte: last_byte_i};

  cbd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .adv_i      (out_ready),
    .valid_o    (item_valid),
    .item_o     (item_q)
  );

  cbd_parser #(
    .CountWidth (CountWidth)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (item_valid && out_ready),
    .item_i (item_q),
    .res_o  (res)
  );

  cbd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (item_valid),
    .ready_o     (out_ready),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_q)
  );

  assign payload_byte_o  = res_q.payload_byte;
  assign payload_valid_o = res_q.payload_valid;
  assign decode_status_o = res_q.decode_status;

endmodule

// File: tb/chunked_body_decoder_tb.sv
// Self-checking testbench for chunked_body_decoder: directed table, then random bodies.
// Expected words: typed table rows, else an in-bench model; needs cbd_pkg and the RTL.
module chunked_body_decoder_tb;

  localparam int CW = cbd_pkg::COUNT_WIDTH;
  localparam int DIR_N = 30;
  localparam int RAND_ITEMS = 1750;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic             typed;
    cbd_pkg::result_t want;
  } dir_row_t;

  localparam cbd_pkg::result_t NO_CHECK = '0;

  // Rows with typed set carry the word the decoder must return; others use the model.
  localparam dir_row_t DIR_TAB [0:DIR_N-1] = '{
    '{cbd_pkg::CHAR_SPACE, 1'b0, 1'b1, '{8'h00, 1'b0, cbd_pkg::STATUS_BUSY}},
    '{cbd_pkg::CHAR_TAB,   1'b0, 1'b0, NO_CHECK},
    '{cbd_pkg::CHAR_ZERO,  1'b0, 1'b0, NO_CHECK},
    '{cbd_pkg::CHAR_X_LO,  1'b0, 1'b0, NO_CHECK},
    '{"2",                 1'b0, 1'b0, NO_CHECK},
    '{"-",                 1'b0, 1'b0, NO_CHECK},  // sign ends the digits
    '{cbd_pkg::CHAR_LF,    1'b0, 1'b0, NO_CHECK},
    '{8'hFF,               1'b0, 1'b1, '{8'hFF, 1'b1, cbd_pkg::STATUS_BUSY}},
    '{8'h00,               1'b0, 1'b1, '{8'h00, 1'b1, cbd_pkg::STATUS_BUSY}},
    '{"1",                 1'b0, 1'b0, NO_CHECK},  // no CR/LF after data: new size line
    '{cbd_pkg::CHAR_LF,    1'b0, 1'b0, NO_CHECK},
    '{"5",                 1'b0, 1'b0, NO_CHECK},
    '{cbd_pkg::CHAR_CR,    1'b0, 1'b0, NO_CHECK},  // CR without its LF
    '{cbd_pkg::CHAR_ZERO,  1'b0, 1'b0, NO_CHECK},
    '{cbd_pkg::CHAR_X_UP,  1'b0, 1'b0, NO_CHECK},
    '{"g",                 1'b0, 1'b0, NO_CHECK},  // prefix without digits: size zero
    '{cbd_pkg::CHAR_LF,    1'b0, 1'b0, NO_CHECK},
    '{"Q",                 1'b0, 1'b0, NO_CHECK},  // ignored after termination
    '{cbd_pkg::CHAR_LF,    1'b1, 1'b1, '{8'h00, 1'b0, cbd_pkg::STATUS_OK}},
    '{"F",                 1'b0, 1'b0, NO_CHECK},  // nine digits saturate the count
    '{"f",                 1'b0, 1'b0, NO_CHECK},
    '{"F",                 1'b0, 1'b0, NO_CHECK},
    '{"f",                 1'b0, 1'b0, NO_CHECK},
    '{"F",                 1'b0, 1'b0, NO_CHECK},
    '{"f",                 1'b0, 1'b0, NO_CHECK},
    '{"F",                 1'b0, 1'b0, NO_CHECK},
    '{"f",                 1'b0, 1'b0, NO_CHECK},
    '{"F",                 1'b0, 1'b0, NO_CHECK},
    '{cbd_pkg::CHAR_CR,    1'b0, 1'b0, NO_CHECK},
    '{cbd_pkg::CHAR_LF,    1'b1, 1'b1, '{8'h00, 1'b0, cbd_pkg::STATUS_BAD}}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] payload_byte_o;
  logic       payload_valid_o;
  logic [1:0] decode_status_o;

  chunked_body_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .payload_byte_o  (payload_byte_o),
    .payload_valid_o (payload_valid_o),
    .decode_status_o (decode_status_o)
  );

  always #6 clk_i = ~clk_i;

  cbd_pkg::result_t decoded_q [$];
  logic [7:0]       body_q [$];
  int               err_count = 0;
  int               sent = 0;
  int               cyc = 0;

  // Decoder model state.
  cbd_pkg::mode_e  pr_mode;
  cbd_pkg::phase_e pr_phase;
  logic [CW-1:0]   pr_left;
  logic            pr_done;

  function automatic void clear_framing();
    pr_mode  = cbd_pkg::MODE_LINE_START;
    pr_phase = cbd_pkg::PHASE_BLANK;
    pr_left  = '0;
    pr_done  = 1'b0;
  endfunction

  function automatic bit hex_digit(input logic [7:0] b, output logic [3:0] v);
    v = 4'd0;
    if (b >= "0" && b <= "9") begin
      v = 4'(b - "0");
      return 1'b1;
    end
    if (b >= "a" && b <= "f") begin
      v = 4'(b - "a" + 8'd10);
      return 1'b1;
    end
    if (b >= "A" && b <= "F") begin
      v = 4'(b - "A" + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void add_digit(input logic [3:0] d);
    logic [CW-1:0] top;
    top = '1;
    if (pr_left > (top - d) / 16) pr_left = top;
    else pr_left = pr_left * 16 + d;
  endfunction

  function automatic void size_line_byte(input logic [7:0] b);
    logic [3:0] v;
    bit         is_hex;
    if (b == cbd_pkg::CHAR_LF) begin
      if (pr_left == '0) pr_done = 1'b1;
      else pr_mode = cbd_pkg::MODE_DATA;
      pr_phase = cbd_pkg::PHASE_BLANK;
      return;
    end
    pr_mode = cbd_pkg::MODE_LINE;
    is_hex = hex_digit(b, v);
    case (pr_phase)
      cbd_pkg::PHASE_BLANK: begin
        if (b == cbd_pkg::CHAR_SPACE || b == cbd_pkg::CHAR_TAB) begin
          pr_phase = cbd_pkg::PHASE_BLANK;
        end else if (b == cbd_pkg::CHAR_ZERO) begin
          pr_phase = cbd_pkg::PHASE_ZERO;
        end else if (is_hex) begin
          add_digit(v);
          pr_phase = cbd_pkg::PHASE_DIGITS;
        end else begin
          pr_phase = cbd_pkg::PHASE_SKIP;
        end
      end
      cbd_pkg::PHASE_ZERO: begin
        if (b == cbd_pkg::CHAR_X_LO || b == cbd_pkg::CHAR_X_UP) begin
          pr_phase = cbd_pkg::PHASE_DIGITS;
        end else if (is_hex) begin
          add_digit(v);
          pr_phase = cbd_pkg::PHASE_DIGITS;
        end else begin
          pr_phase = cbd_pkg::PHASE_SKIP;
        end
      end
      cbd_pkg::PHASE_DIGITS: begin
        if (is_hex) add_digit(v);
        else pr_phase = cbd_pkg::PHASE_SKIP;
      end
      default: ;
    endcase
  endfunction

  function automatic cbd_pkg::result_t decode_step(input logic [7:0] b, input logic last);
    cbd_pkg::result_t r;
    r = '{8'h00, 1'b0, cbd_pkg::STATUS_BUSY};
    if (!pr_done) begin
      case (pr_mode)
        cbd_pkg::MODE_DATA: begin
          r.payload_byte  = b;
          r.payload_valid = 1'b1;
          pr_left = pr_left - 1'b1;
          if (pr_left == '0) pr_mode = cbd_pkg::MODE_OPT_CR;
        end
        cbd_pkg::MODE_OPT_CR: begin
          if (b == cbd_pkg::CHAR_CR) pr_mode = cbd_pkg::MODE_OPT_LF;
          else if (b == cbd_pkg::CHAR_LF) pr_mode = cbd_pkg::MODE_LINE_START;
          else size_line_byte(b);
        end
        cbd_pkg::MODE_OPT_LF: begin
          if (b == cbd_pkg::CHAR_LF) pr_mode = cbd_pkg::MODE_LINE_START;
          else size_line_byte(b);
        end
        default: size_line_byte(b);
      endcase
    end
    if (last) begin
      if (!pr_done && (pr_mode == cbd_pkg::MODE_LINE || pr_mode == cbd_pkg::MODE_DATA)) begin
        r.decode_status = cbd_pkg::STATUS_BAD;
      end else begin
        r.decode_status = cbd_pkg::STATUS_OK;
      end
      clear_framing();
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
    if (nib < 4'd10) return "0" + nib;
    return ($urandom_range(1) ? "A" : "a") + nib - 8'd10;
  endfunction

  function automatic logic [7:0] odd_char();
    case ($urandom_range(10))
      0: return cbd_pkg::CHAR_CR;
      1: return cbd_pkg::CHAR_LF;
      2: return cbd_pkg::CHAR_SPACE;
      3: return cbd_pkg::CHAR_TAB;
      4: return cbd_pkg::CHAR_ZERO;
      5: return cbd_pkg::CHAR_X_LO;
      6: return cbd_pkg::CHAR_X_UP;
      7: return "-";
      8: return "+";
      9: return "f";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic put_size_line(input logic [31:0] size);
    bit started;
    started = 1'b0;
    repeat ($urandom_range(0, 2)) begin
      body_q.push_back($urandom_range(1) ? cbd_pkg::CHAR_SPACE : cbd_pkg::CHAR_TAB);
    end
    if ($urandom_range(99) < 25) begin
      body_q.push_back(cbd_pkg::CHAR_ZERO);
      body_q.push_back($urandom_range(1) ? cbd_pkg::CHAR_X_UP : cbd_pkg::CHAR_X_LO);
    end
    if ($urandom_range(99) < 15) body_q.push_back(cbd_pkg::CHAR_ZERO);
    for (int i = 7; i >= 0; i--) begin
      if (started || size[4*i +: 4] != 4'd0 || i == 0) begin
        body_q.push_back(hex_glyph(size[4*i +: 4]));
        started = 1'b1;
      end
    end
    if ($urandom_range(99) < 15) begin
      body_q.push_back(";");
      repeat ($urandom_range(1, 3)) body_q.push_back(8'($urandom_range("a", "z")));
    end
    if ($urandom_range(99) < 85) body_q.push_back(cbd_pkg::CHAR_CR);
    body_q.push_back(cbd_pkg::CHAR_LF);
  endtask

  task automatic gen_body();
    int          kind;
    int          tail;
    logic [31:0] size;
    body_q.delete();
    kind = $urandom_range(99);
    if (kind < 12) begin
      // Noise, sometimes behind an oversized count.
      if ($urandom_range(99) < 30) begin
        repeat ($urandom_range(9, 10)) body_q.push_back($urandom_range(1) ? "F" : "f");
        body_q.push_back(cbd_pkg::CHAR_LF);
      end
      repeat ($urandom_range(1, 16)) body_q.push_back(odd_char());
    end else begin
      repeat ($urandom_range(1, 4)) begin
        size = ($urandom_range(99) < 10) ? $urandom_range(11, 48) : $urandom_range(1, 10);
        put_size_line(size);
        repeat (size) body_q.push_back(8'($urandom_range(0, 255)));
        tail = $urandom_range(99);
        if (tail < 75) begin
          body_q.push_back(cbd_pkg::CHAR_CR);
          body_q.push_back(cbd_pkg::CHAR_LF);
        end else if (tail < 85) begin
          body_q.push_back(cbd_pkg::CHAR_CR);
        end else if (tail < 93) begin
          body_q.push_back(cbd_pkg::CHAR_LF);
        end
      end
      if ($urandom_range(99) < 90) put_size_line(32'd0);
      if ($urandom_range(99) < 20) begin
        repeat ($urandom_range(1, 4)) body_q.push_back(8'($urandom_range(0, 255)));
      end
      // Break some bodies: corrupt a few words or cut the tail off.
      if (kind < 27) begin
        repeat ($urandom_range(1, 3)) body_q[$urandom_range(0, body_q.size() - 1)] = odd_char();
      end
      if ($urandom_range(99) < 10) body_q = body_q[0:$urandom_range(0, body_q.size() - 1)];
    end
  endtask

  // Offer one word, hold it until taken, then log the expected result.
  task automatic send_word(input logic [7:0] b, input logic last, input logic typed,
                           input cbd_pkg::result_t typed_res);
    cbd_pkg::result_t pred;
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    pred = decode_step(b, last);
    decoded_q.push_back(typed ? typed_res : pred);
  endtask

  task automatic maybe_idle(input bit quiet);
    if (!quiet && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (decoded_q.size() != 0);
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    clear_framing();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < DIR_N; i++) begin
      send_word(DIR_TAB[i].data, DIR_TAB[i].last, DIR_TAB[i].typed, DIR_TAB[i].want);
      maybe_idle(1'b0);
    end
    drain();
    while (sent < RAND_ITEMS) begin
      gen_body();
      foreach (body_q[k]) begin
        send_word(body_q[k], k == body_q.size() - 1, 1'b0, NO_CHECK);
        sent++;
        maybe_idle(sent >= 400 && sent < 800);
      end
      // Hold off once until everything in flight is back.
      if (!paused && sent > 1000) begin
        drain();
        paused = 1'b1;
      end
    end
    drain();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Receiver stall: one long hold-off, one quiet stretch, random otherwise.
  initial begin
    int rx_cycle;
    rx_cycle = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (rx_cycle >= 200 && rx_cycle < 260) out_stall_i <= 1'b1;
      else if (rx_cycle >= 500 && rx_cycle < 900) out_stall_i <= 1'b0;
      else out_stall_i <= ($urandom_range(99) < 8);
    end
  end

  always @(posedge clk_i) begin : check_blk
    cbd_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        $error("result word with nothing expected: byte %0h valid %0b status %0d",
               payload_byte_o, payload_valid_o, decode_status_o);
        err_count++;
      end else begin
        want = decoded_q.pop_front();
        if (payload_byte_o !== want.payload_byte) begin
          $error("payload_byte: expected %0h, got %0h", want.payload_byte, payload_byte_o);
          err_count++;
        end
        if (payload_valid_o !== want.payload_valid) begin
          $error("payload_valid: expected %0b, got %0b", want.payload_valid, payload_valid_o);
          err_count++;
        end
        if (decode_status_o !== want.decode_status) begin
          $error("decode_status: expected %0d, got %0d", want.decode_status, decode_status_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc++;
    if (cyc >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

// File: sim.f
rtl/cbd_pkg.sv
rtl/cbd_in_reg.sv
rtl/cbd_parser.sv
rtl/cbd_out_reg.sv
rtl/chunked_body_decoder.sv
tb/chunked_body_decoder_tb.sv
